// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define ASSERT_IMPLIES(lbl, clk, rst_n, lhs, rhs) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, lhs, rhs) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/arpic_pkg.sv -----
package arpic_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 2048;

  // command codes on the input tuser
  localparam logic [1:0] CMD_BYTE      = 2'd0;
  localparam logic [1:0] CMD_CLR_COUNT = 2'd1;
  localparam logic [1:0] CMD_INV_CACHE = 2'd2;

  // verdict codes
  localparam logic [1:0] CLS_IGNORED   = 2'd0;
  localparam logic [1:0] CLS_ARP_REPLY = 2'd1;
  localparam logic [1:0] CLS_ECHO_REPLY = 2'd2;

  localparam logic [15:0] ETHER_ARP  = 16'h0806;
  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_OPCODE_REPLY = 16'd2;
  localparam logic [7:0]  IPV4_PROTO_ICMP = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REPLY_TYPE = 8'd0;

  localparam int MIN_IP_LEN  = 14 + 20 + 8;
  localparam int MIN_ARP_LEN = 14 + 28;

  // header byte offsets
  localparam int OFS_ETHER_HI = 12;
  localparam int OFS_ETHER_LO = 13;
  localparam int OFS_OP_HI    = 20;
  localparam int OFS_OP_LO    = 21;
  localparam int OFS_MAC_FIRST = 22;
  localparam int OFS_MAC_LAST  = 27;
  localparam int OFS_IP_PROTO  = 23;
  localparam int OFS_SRC_FIRST = 26;
  localparam int OFS_SRC_LAST  = 29;
  localparam int OFS_SPA_FIRST = 28;
  localparam int OFS_SPA_LAST  = 31;
  localparam int OFS_ICMP_TYPE = 34;

  localparam int OUT_TDATA_W = 104;

  typedef struct packed {
    logic [47:0] cached_mac;
    logic [31:0] cached_ip;
    logic        cache_hit;
    logic        cache_valid;
    logic [15:0] frames_seen;
    logic [1:0]  frame_class;
  } result_t;

endpackage

// ----- sv/arp_icmp_reply_frame_classifier_unit.sv -----
// channel  direction  tdata                          tuser        tlast
// in_      slave      frame_byte                     cmd          last_byte
// out_     master     frames_seen..cached_mac        frame_class  -
// cfg_     slave      target address (cfg_data)      -            -
//
// one beat accepted per cycle while in_tready is high; header capture and the
// verdict are settled in the cycle the beat is taken, and the verdict appears on
// out_ the next cycle when the output register is free
// a two-entry output register lets input beats keep flowing while one verdict waits
// in_tready drops only when both output entries are full
// rst_n is synchronous, active low; it clears the cache, counter and target
module arp_icmp_reply_frame_classifier_unit #(
  parameter int MAX_FRAME_BYTES = arpic_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] frame_byte
  input  logic [1:0]   in_tuser,   // [1:0] cmd
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] frames_seen, [16] cache_valid, [17] cache_hit, [49:18] cached_ip,
  // [97:50] cached_mac, [103:98] zero
  output logic [arpic_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] frame_class
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  arpic_pkg::result_t res, res_q;
  logic               res_push;
  logic               acc;

  assign cfg_ready = 1'b1;
  assign acc       = in_tvalid && in_tready;

  arpic_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .acc        (acc),
    .cmd        (in_tuser),
    .frame_byte (in_tdata),
    .last_byte  (in_tlast),
    .res_push   (res_push),
    .res        (res)
  );

  arpic_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_q)
  );

  assign out_tuser = res_q.frame_class;
  assign out_tdata = {6'd0, res_q.cached_mac, res_q.cached_ip, res_q.cache_hit,
                      res_q.cache_valid, res_q.frames_seen};

endmodule

// ----- sv/arpic_parse.sv -----
module arpic_parse #(
  parameter int MAX_FRAME_BYTES = arpic_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic               acc,
  input  logic [1:0]         cmd,
  input  logic [7:0]         frame_byte,
  input  logic               last_byte,
  output logic               res_push,
  output arpic_pkg::result_t res
);

  localparam int PosW = $clog2(MAX_FRAME_BYTES);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES - 1);

  logic [31:0]     tgt_ip_r;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0]     kind_r, kind_nxt;
  logic [15:0]     op_r, op_nxt;
  logic [7:0]      proto_r, proto_nxt;
  logic [31:0]     src_r, src_nxt;
  logic [7:0]      icmp_r, icmp_nxt;
  logic [31:0]     spa_r, spa_nxt;
  logic [47:0]     sha_r, sha_nxt;
  logic [31:0]     cip_r, cip_nxt;
  logic [47:0]     cmac_r, cmac_nxt;
  logic            cval_r, cval_nxt;
  logic [15:0]     cnt_r, cnt_nxt;
  logic [1:0]      cls;
  logic            frame_end;

  function automatic logic at(input logic [PosW-1:0] p, input int ofs);
    return p == PosW'(ofs);
  endfunction

  function automatic logic span(input logic [PosW-1:0] p, input int lo, input int hi);
    return (p >= PosW'(lo)) && (p <= PosW'(hi));
  endfunction

  // header fields with the current byte folded in
  always_comb begin
    kind_nxt  = (at(pos_r, arpic_pkg::OFS_ETHER_HI) || at(pos_r, arpic_pkg::OFS_ETHER_LO)) ?
                {kind_r[7:0], frame_byte} : kind_r;
    op_nxt    = (at(pos_r, arpic_pkg::OFS_OP_HI) || at(pos_r, arpic_pkg::OFS_OP_LO)) ?
                {op_r[7:0], frame_byte} : op_r;
    sha_nxt   = span(pos_r, arpic_pkg::OFS_MAC_FIRST, arpic_pkg::OFS_MAC_LAST) ?
                {sha_r[39:0], frame_byte} : sha_r;
    proto_nxt = at(pos_r, arpic_pkg::OFS_IP_PROTO) ? frame_byte : proto_r;
    src_nxt   = span(pos_r, arpic_pkg::OFS_SRC_FIRST, arpic_pkg::OFS_SRC_LAST) ?
                {src_r[23:0], frame_byte} : src_r;
    spa_nxt   = span(pos_r, arpic_pkg::OFS_SPA_FIRST, arpic_pkg::OFS_SPA_LAST) ?
                {spa_r[23:0], frame_byte} : spa_r;
    icmp_nxt  = at(pos_r, arpic_pkg::OFS_ICMP_TYPE) ? frame_byte : icmp_r;
    pos_nxt   = (pos_r < PosMax) ? pos_r + PosW'(1) : pos_r;
  end

  assign frame_end = acc && (cmd == arpic_pkg::CMD_BYTE) && last_byte;

  // verdict and cache update at the last beat of a frame
  always_comb begin
    cls      = arpic_pkg::CLS_IGNORED;
    cip_nxt  = cip_r;
    cmac_nxt = cmac_r;
    cval_nxt = cval_r;
    cnt_nxt  = (cnt_r != 16'hFFFF) ? cnt_r + 16'd1 : cnt_r;
    if (kind_nxt == arpic_pkg::ETHER_ARP) begin
      if (pos_r >= PosW'(arpic_pkg::MIN_ARP_LEN - 1) &&
          op_nxt == arpic_pkg::ARP_OPCODE_REPLY) begin
        cip_nxt  = spa_nxt;
        cmac_nxt = sha_nxt;
        cval_nxt = 1'b1;
        cls      = arpic_pkg::CLS_ARP_REPLY;
      end
    end else if (kind_nxt == arpic_pkg::ETHER_IPV4) begin
      if (pos_r >= PosW'(arpic_pkg::MIN_IP_LEN - 1) &&
          proto_nxt == arpic_pkg::IPV4_PROTO_ICMP &&
          src_nxt == tgt_ip_r && icmp_nxt == arpic_pkg::ICMP_ECHO_REPLY_TYPE) begin
        cls = arpic_pkg::CLS_ECHO_REPLY;
      end
    end
  end

  assign res_push        = frame_end;
  assign res.frame_class = cls;
  assign res.frames_seen = cnt_nxt;
  assign res.cache_valid = cval_nxt;
  assign res.cache_hit   = cval_nxt && (cip_nxt == tgt_ip_r);
  assign res.cached_ip   = cip_nxt;
  assign res.cached_mac  = cmac_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_ip_r <= '0;
      pos_r   <= '0;
      kind_r  <= '0;
      op_r    <= '0;
      proto_r <= '0;
      src_r   <= '0;
      icmp_r  <= '0;
      spa_r   <= '0;
      sha_r   <= '0;
      cip_r   <= '0;
      cmac_r  <= '0;
      cval_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        tgt_ip_r <= cfg_data;
      end
      if (acc) begin
        unique case (cmd)
          arpic_pkg::CMD_BYTE: begin
            if (last_byte) begin
              pos_r   <= '0;
              kind_r  <= '0;
              op_r    <= '0;
              proto_r <= '0;
              src_r   <= '0;
              icmp_r  <= '0;
              spa_r   <= '0;
              sha_r   <= '0;
              cip_r   <= cip_nxt;
              cmac_r  <= cmac_nxt;
              cval_r  <= cval_nxt;
              cnt_r   <= cnt_nxt;
            end else begin
              pos_r   <= pos_nxt;
              kind_r  <= kind_nxt;
              op_r    <= op_nxt;
              proto_r <= proto_nxt;
              src_r   <= src_nxt;
              icmp_r  <= icmp_nxt;
              spa_r   <= spa_nxt;
              sha_r   <= sha_nxt;
            end
          end
          arpic_pkg::CMD_CLR_COUNT: cnt_r <= '0;
          arpic_pkg::CMD_INV_CACHE: cval_r <= 1'b0;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sv/arpic_out_buf.sv -----
module arpic_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  arpic_pkg::result_t push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output arpic_pkg::result_t out_data
);

  arpic_pkg::result_t main_r, skid_r;
  logic               main_valid_r, skid_valid_r;
  logic               main_free;

  assign main_free = !main_valid_r || out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// ----- sv/arpic_checker.sv -----
`include "assert_macros.svh"

module arpic_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [arpic_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]   out_tuser
);

  logic out_stall;
  logic out_arp;

  assign out_stall = out_tvalid && !out_tready;
  assign out_arp   = out_tvalid && (out_tuser == arpic_pkg::CLS_ARP_REPLY);

  // a stalled verdict holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable({out_tuser, out_tdata}))

  // verdict counts its own frame
  `ASSERT_IMPLIES(a_count_nonzero, clk, rst_n, out_tvalid, out_tdata[15:0] != 16'd0)

  // a hit needs a valid entry
  `ASSERT_IMPLIES(a_hit_valid, clk, rst_n, out_tvalid && out_tdata[17], out_tdata[16])

  // a captured reply leaves the cache valid
  `ASSERT_IMPLIES(a_arp_valid, clk, rst_n, out_arp, out_tdata[16])

  // no verdict code beyond echo reply
  `ASSERT_IMPLIES(a_class_code, clk, rst_n, out_tvalid, out_tuser <= arpic_pkg::CLS_ECHO_REPLY)

endmodule

bind arp_icmp_reply_frame_classifier_unit arpic_checker u_arpic_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

  // a small frame limit keeps the oversized frame short
  localparam int FRAME_MAX = 64;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       tail;
  } beat_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [arpic_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  arp_icmp_reply_frame_classifier_unit #(
    .MAX_FRAME_BYTES(FRAME_MAX)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // beats waiting to be offered, verdicts waiting to come out
  beat_t              rx_beats[$];
  arpic_pkg::result_t verdicts_due[$];
  int unsigned bytes_queued = 0;
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [31:0] stim_target = '0;
  logic        in_taken = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  // classifier shadow state
  int unsigned hdr_pos;
  logic [15:0] seen_etype, seen_op;
  logic [7:0]  seen_proto, seen_icmp;
  logic [31:0] seen_src, seen_spa;
  logic [47:0] seen_sha;
  logic [31:0] cache_ip, match_ip;
  logic [47:0] cache_mac;
  logic        cache_ok;
  logic [15:0] frame_count;

  task automatic classify_beat(input beat_t bt);
    int unsigned span;
    arpic_pkg::result_t v;
    case (bt.cmd)
      arpic_pkg::CMD_CLR_COUNT: frame_count = '0;
      arpic_pkg::CMD_INV_CACHE: cache_ok = 1'b0;
      arpic_pkg::CMD_BYTE: begin
        if (hdr_pos == arpic_pkg::OFS_ETHER_HI || hdr_pos == arpic_pkg::OFS_ETHER_LO)
          seen_etype = {seen_etype[7:0], bt.data};
        if (hdr_pos == arpic_pkg::OFS_OP_HI || hdr_pos == arpic_pkg::OFS_OP_LO)
          seen_op = {seen_op[7:0], bt.data};
        if (hdr_pos >= arpic_pkg::OFS_MAC_FIRST && hdr_pos <= arpic_pkg::OFS_MAC_LAST)
          seen_sha = {seen_sha[39:0], bt.data};
        if (hdr_pos == arpic_pkg::OFS_IP_PROTO)
          seen_proto = bt.data;
        if (hdr_pos >= arpic_pkg::OFS_SRC_FIRST && hdr_pos <= arpic_pkg::OFS_SRC_LAST)
          seen_src = {seen_src[23:0], bt.data};
        if (hdr_pos >= arpic_pkg::OFS_SPA_FIRST && hdr_pos <= arpic_pkg::OFS_SPA_LAST)
          seen_spa = {seen_spa[23:0], bt.data};
        if (hdr_pos == arpic_pkg::OFS_ICMP_TYPE)
          seen_icmp = bt.data;
        span = hdr_pos + 1;
        // position sticks at the top for oversized frames
        if (hdr_pos < FRAME_MAX - 1)
          hdr_pos++;
        if (bt.tail) begin
          if (frame_count != 16'hFFFF)
            frame_count++;
          v.frame_class = arpic_pkg::CLS_IGNORED;
          if (seen_etype == arpic_pkg::ETHER_ARP) begin
            if (span >= arpic_pkg::MIN_ARP_LEN && seen_op == arpic_pkg::ARP_OPCODE_REPLY) begin
              cache_ip = seen_spa;
              cache_mac = seen_sha;
              cache_ok = 1'b1;
              v.frame_class = arpic_pkg::CLS_ARP_REPLY;
            end
          end else if (seen_etype == arpic_pkg::ETHER_IPV4) begin
            if (span >= arpic_pkg::MIN_IP_LEN && seen_proto == arpic_pkg::IPV4_PROTO_ICMP &&
                seen_src == match_ip && seen_icmp == arpic_pkg::ICMP_ECHO_REPLY_TYPE)
              v.frame_class = arpic_pkg::CLS_ECHO_REPLY;
          end
          hdr_pos = 0;
          seen_etype = '0;
          seen_op = '0;
          seen_proto = '0;
          seen_src = '0;
          seen_icmp = '0;
          seen_spa = '0;
          seen_sha = '0;
          v.frames_seen = frame_count;
          v.cache_valid = cache_ok;
          v.cache_hit = cache_ok && (cache_ip == match_ip);
          v.cached_ip = cache_ip;
          v.cached_mac = cache_mac;
          verdicts_due.push_back(v);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // checker and shadow model, all sampled at the rising edge
  always @(posedge clk) begin
    arpic_pkg::result_t want, got;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      hdr_pos = 0;
      seen_etype = '0;
      seen_op = '0;
      seen_proto = '0;
      seen_src = '0;
      seen_icmp = '0;
      seen_spa = '0;
      seen_sha = '0;
      cache_ip = '0;
      cache_mac = '0;
      cache_ok = 1'b0;
      frame_count = '0;
      match_ip = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.frame_class = out_tuser;
        got.frames_seen = out_tdata[15:0];
        got.cache_valid = out_tdata[16];
        got.cache_hit = out_tdata[17];
        got.cached_ip = out_tdata[49:18];
        got.cached_mac = out_tdata[97:50];
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict, expected none, got %0h", $time, got);
        end else begin
          want = verdicts_due.pop_front();
          check_field("frame_class", 64'(want.frame_class), 64'(got.frame_class));
          check_field("frames_seen", 64'(want.frames_seen), 64'(got.frames_seen));
          check_field("cache_valid", 64'(want.cache_valid), 64'(got.cache_valid));
          check_field("cache_hit", 64'(want.cache_hit), 64'(got.cache_hit));
          check_field("cached_ip", 64'(want.cached_ip), 64'(got.cached_ip));
          check_field("cached_mac", 64'(want.cached_mac), 64'(got.cached_mac));
          check_field("tdata padding", 64'd0, 64'(out_tdata[103:98]));
        end
      end
      if (cfg_valid && cfg_ready)
        match_ip = cfg_data;
      if (in_tvalid && in_tready)
        classify_beat('{in_tuser, in_tdata, in_tlast});
    end
  end

  // byte source
  always @(negedge clk) begin
    beat_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (rx_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = rx_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.cmd;
        in_tdata <= nxt.data;
        in_tlast <= nxt.tail;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // verdict sink, with a long hold-off each time hold_go toggles
  always @(negedge clk) begin
    if (hold_go != hold_ack) begin
      hold_ack <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_beat(input logic [1:0] cmd, input logic [7:0] data, input logic tail);
    rx_beats.push_back('{cmd, data, tail});
    if (cmd == arpic_pkg::CMD_BYTE)
      bytes_queued++;
  endtask

  // builds one frame; cmd_pct is the chance of a command beat before each byte
  task automatic queue_frame(input logic [15:0] etype, input int unsigned len,
                             input logic [15:0] op, input logic [7:0] proto,
                             input logic [31:0] addr, input logic [47:0] mac,
                             input logic [7:0] icmp_t, input int unsigned cmd_pct);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == arpic_pkg::OFS_ETHER_HI) begin
        b = etype[15:8];
      end else if (i == arpic_pkg::OFS_ETHER_LO) begin
        b = etype[7:0];
      end else if (etype == arpic_pkg::ETHER_ARP) begin
        if (i == arpic_pkg::OFS_OP_HI)
          b = op[15:8];
        else if (i == arpic_pkg::OFS_OP_LO)
          b = op[7:0];
        else if (i >= arpic_pkg::OFS_MAC_FIRST && i <= arpic_pkg::OFS_MAC_LAST)
          b = mac[8*(arpic_pkg::OFS_MAC_LAST - i) +: 8];
        else if (i >= arpic_pkg::OFS_SPA_FIRST && i <= arpic_pkg::OFS_SPA_LAST)
          b = addr[8*(arpic_pkg::OFS_SPA_LAST - i) +: 8];
      end else begin
        if (i == arpic_pkg::OFS_IP_PROTO)
          b = proto;
        else if (i >= arpic_pkg::OFS_SRC_FIRST && i <= arpic_pkg::OFS_SRC_LAST)
          b = addr[8*(arpic_pkg::OFS_SRC_LAST - i) +: 8];
        else if (i == arpic_pkg::OFS_ICMP_TYPE)
          b = icmp_t;
      end
      if (cmd_pct != 0 && $urandom_range(99) < cmd_pct)
        push_beat(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(1)));
      push_beat(arpic_pkg::CMD_BYTE, b, i == len - 1);
    end
  endtask

  // mostly well-formed replies aimed at the target, with some noise mixed in
  task automatic queue_random_frame(input int unsigned max_len);
    int unsigned pick, len;
    logic [15:0] etype, op;
    logic [7:0]  proto, icmp_t;
    logic [31:0] addr;
    logic [47:0] mac;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0)
      len = $urandom_range(1, arpic_pkg::MIN_ARP_LEN - 1);
    else
      len = $urandom_range(arpic_pkg::MIN_ARP_LEN, max_len);
    addr = ($urandom_range(3) == 0) ? $urandom : stim_target;
    if ($urandom_range(7) == 0)
      addr = addr ^ (32'h1 << $urandom_range(31));
    mac = 48'({$urandom, $urandom});
    op = ($urandom_range(4) != 0) ? arpic_pkg::ARP_OPCODE_REPLY :
         ($urandom_range(1) != 0) ? 16'd1 : 16'($urandom);
    proto = ($urandom_range(4) != 0) ? arpic_pkg::IPV4_PROTO_ICMP : 8'($urandom);
    icmp_t = ($urandom_range(4) != 0) ? arpic_pkg::ICMP_ECHO_REPLY_TYPE :
             ($urandom_range(1) != 0) ? 8'd8 : 8'($urandom);
    if (pick < 45)
      etype = arpic_pkg::ETHER_ARP;
    else if (pick < 90)
      etype = arpic_pkg::ETHER_IPV4;
    else if (pick < 95)
      etype = arpic_pkg::ETHER_IPV4 ^ (16'h1 << $urandom_range(15));
    else
      etype = 16'($urandom);
    queue_frame(etype, len, op, proto, addr, mac, icmp_t, 4);
  endtask

  // wait until the block has nothing left in flight
  task automatic settle();
    while (rx_beats.size() != 0 || in_tvalid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_target(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    stim_target = value;
  endtask

  initial begin
    int unsigned ph_start, ph_frames;
    logic [31:0] tgt;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed frames
    write_target(32'hC0A8_0001);
    queue_frame(arpic_pkg::ETHER_ARP, arpic_pkg::MIN_ARP_LEN, arpic_pkg::ARP_OPCODE_REPLY,
                8'h00, stim_target, 48'hFFFF_FFFF_FFFF, 8'h00, 0);
    queue_frame(arpic_pkg::ETHER_IPV4, arpic_pkg::MIN_IP_LEN, 16'h0000,
                arpic_pkg::IPV4_PROTO_ICMP, stim_target, 48'h0,
                arpic_pkg::ICMP_ECHO_REPLY_TYPE, 0);
    queue_frame(arpic_pkg::ETHER_ARP, arpic_pkg::MIN_ARP_LEN - 1, arpic_pkg::ARP_OPCODE_REPLY,
                8'h00, 32'h0A00_0001, 48'h0011_2233_4455, 8'h00, 0);
    queue_frame(arpic_pkg::ETHER_IPV4, arpic_pkg::MIN_IP_LEN - 1, 16'h0000,
                arpic_pkg::IPV4_PROTO_ICMP, stim_target, 48'h0,
                arpic_pkg::ICMP_ECHO_REPLY_TYPE, 0);
    queue_frame(arpic_pkg::ETHER_ARP, 44, 16'd1, 8'h00, stim_target, 48'h0A0B_0C0D_0E0F,
                8'h00, 0);
    queue_frame(arpic_pkg::ETHER_IPV4, 42, 16'h0000, 8'd6, stim_target, 48'h0,
                arpic_pkg::ICMP_ECHO_REPLY_TYPE, 0);
    queue_frame(arpic_pkg::ETHER_IPV4, 42, 16'h0000, arpic_pkg::IPV4_PROTO_ICMP,
                stim_target, 48'h0, 8'd8, 0);
    queue_frame(arpic_pkg::ETHER_IPV4, 42, 16'h0000, arpic_pkg::IPV4_PROTO_ICMP,
                32'hC0A8_0002, 48'h0, arpic_pkg::ICMP_ECHO_REPLY_TYPE, 0);
    queue_frame(16'h86DD, 42, arpic_pkg::ARP_OPCODE_REPLY, arpic_pkg::IPV4_PROTO_ICMP,
                stim_target, 48'h0, arpic_pkg::ICMP_ECHO_REPLY_TYPE, 0);
    queue_frame(arpic_pkg::ETHER_ARP, 1, arpic_pkg::ARP_OPCODE_REPLY, 8'h00, 32'h0, 48'h0,
                8'h00, 0);
    // invalidated cache keeps its addresses but reads as not valid
    push_beat(arpic_pkg::CMD_INV_CACHE, 8'hFF, 1'b1);
    queue_frame(arpic_pkg::ETHER_IPV4, 42, 16'h0000, arpic_pkg::IPV4_PROTO_ICMP,
                stim_target, 48'h0, arpic_pkg::ICMP_ECHO_REPLY_TYPE, 0);
    push_beat(arpic_pkg::CMD_CLR_COUNT, 8'h00, 1'b0);
    push_beat(CMD_UNUSED, 8'hA5, 1'b1);
    // commands in the middle of frames
    queue_frame(arpic_pkg::ETHER_ARP, 42, arpic_pkg::ARP_OPCODE_REPLY, 8'h00, 32'h0, 48'h0,
                8'h00, 30);
    queue_frame(arpic_pkg::ETHER_IPV4, 42, 16'h0000, arpic_pkg::IPV4_PROTO_ICMP,
                stim_target, 48'h0, arpic_pkg::ICMP_ECHO_REPLY_TYPE, 30);
    // oversized frame, position saturates
    queue_frame(arpic_pkg::ETHER_ARP, FRAME_MAX + 6, arpic_pkg::ARP_OPCODE_REPLY, 8'h00,
                32'hFFFF_FFFF, 48'h8000_0000_0001, 8'h00, 0);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: tgt = 32'hFFFF_FFFF;
        1: tgt = 32'h0000_0000;
        default: tgt = $urandom;
      endcase
      write_target(tgt);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      ph_start = bytes_queued;
      ph_frames = 0;
      if (ph == 0) begin
        // short frames pile up behind a long sink hold-off
        for (int k = 0; k < 12; k++)
          queue_frame(arpic_pkg::ETHER_ARP, $urandom_range(1, 8), arpic_pkg::ARP_OPCODE_REPLY,
                      8'h00, 32'h0, 48'h0, 8'h00, 0);
        hold_go = !hold_go;
      end
      while (bytes_queued - ph_start < 120 || ph_frames < 2) begin
        queue_random_frame(($urandom_range(15) == 0) ? 120 : 60);
        ph_frames++;
      end
      settle();
    end

    // counter clear ahead of a final echo reply, no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_beat(arpic_pkg::CMD_CLR_COUNT, 8'($urandom), 1'b0);
    queue_frame(arpic_pkg::ETHER_IPV4, arpic_pkg::MIN_IP_LEN, 16'h0000,
                arpic_pkg::IPV4_PROTO_ICMP, stim_target, 48'h0,
                arpic_pkg::ICMP_ECHO_REPLY_TYPE, 0);

    while (rx_beats.size() != 0 || in_tvalid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
